FILE: design/varint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_pkg: shared types and constants of the varint codec
// Item and result structs, function and kind codes, byte limit.
// ----------------------------------------------------------------------------
package varint_pkg;

    localparam int MAX_BYTES = 10;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic               func;
        logic               signed_form;
        logic signed [63:0] value_in;
        logic [3:0]         room;
        logic [7:0]         in_byte;
        logic               buffer_end;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic               last;
        logic signed [63:0] value_out;
        logic [3:0]         byte_count;
    } result_t;

endpackage

FILE: design/varint_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_codec: LEB128 / sign-magnitude variable-length integer codec
// Encodes 64-bit values into 1 to 10 bytes and decodes one byte per item.
// ----------------------------------------------------------------------------
// A new item can be taken every cycle unless the item side stalls. An
// accepted item sits in the work register; a decode item leaves it as soon as
// the result register is free, an encode item once its last byte or its room
// error has gone there, since the single result register takes one result
// per cycle while the result side does not stall. Each result goes from the
// work register to the result register, where it is presented. A decode byte
// with its continuation bit set gives no result; the value, its byte count,
// or an error comes with the byte that ends the value. Encoding never touches
// a partly decoded value. Stall on the result side holds the result register
// and, once the work register cannot drain, stalls the item side.
module varint_codec
    import varint_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef struct packed {
        logic        func;
        logic        sform;
        logic [63:0] mag;
        logic        sbit;
        logic [3:0]  n;
        logic        err;
        logic [7:0]  in_byte;
        logic        buffer_end;
    } work_t;

    // bit offset of 7-bit group k; signed form has a 6-bit first group
    function automatic logic [5:0] grp_shift(input logic sform, input logic [3:0] k);
        logic [6:0] t;
        t = 7'(k) * 7'd7;
        if (sform && k != 4'd0)
        begin
            t = t - 7'd1;
        end
        return t[5:0];
    endfunction

    logic        work_valid_reg, work_valid_next;
    work_t       work_reg, work_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  bytes_seen_reg, bytes_seen_next;
    logic        sign_seen_reg, sign_seen_next;
    logic        form_latched_reg, form_latched_next;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    // accept side
    logic [63:0]          raw;
    logic [63:0]          mag;
    logic                 neg;
    logic [MAX_BYTES-1:0] grp_nz;
    logic [6:0]           grp_in;
    logic [3:0]           n_need;

    // work side
    logic        out_free, fire, work_done, accept;
    logic [6:0]  grp;
    logic [6:0]  data7;
    logic        last_enc;
    logic        first;
    logic        form;
    logic        sign;
    logic [6:0]  b7;
    logic [63:0] acc_new;
    logic [3:0]  cnt_new;
    logic        dec_val, dec_err;

    always_comb
    begin
        raw = $unsigned(item.value_in);
        neg = item.signed_form && raw[63];
        mag = neg ? (64'd0 - raw) : raw;
        for (int g = 0; g < MAX_BYTES; g++)
        begin
            grp_in = 7'(mag >> grp_shift(item.signed_form, 4'(g)));
            grp_nz[g] = (item.signed_form && g == 0) ? (|grp_in[5:0]) : (|grp_in);
        end
        n_need = 4'd1;
        for (int g = 1; g < MAX_BYTES; g++)
        begin
            if (grp_nz[g])
            begin
                n_need = 4'(g + 1);
            end
        end
    end

    always_comb
    begin
        // encode byte at the current index
        grp      = 7'(work_reg.mag >> grp_shift(work_reg.sform, idx_reg));
        data7    = (idx_reg == 4'd0 && work_reg.sform) ? {work_reg.sbit, grp[5:0]} : grp;
        last_enc = (idx_reg == work_reg.n - 4'd1);

        // decode accumulation
        first   = (bytes_seen_reg == 4'd0);
        form    = first ? work_reg.sform : form_latched_reg;
        sign    = first ? (work_reg.sform && work_reg.in_byte[6]) : sign_seen_reg;
        b7      = (first && form) ? {1'b0, work_reg.in_byte[5:0]} : work_reg.in_byte[6:0];
        acc_new = (first ? 64'd0 : acc_reg) | (64'(b7) << grp_shift(form, bytes_seen_reg));
        cnt_new = bytes_seen_reg + 4'd1;
        dec_val = !work_reg.in_byte[7];
        dec_err = work_reg.in_byte[7]
                  && (cnt_new >= 4'(MAX_BYTES) || work_reg.buffer_end);

        // handshake
        out_free   = !result_valid_reg || !result_stall;
        fire       = work_valid_reg && out_free;
        work_done  = fire && (work_reg.func == FUNC_DECODE || work_reg.err || last_enc);
        item_stall = work_valid_reg && !work_done;
        accept     = item_valid && !item_stall;

        work_valid_next   = work_valid_reg;
        work_next         = work_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        bytes_seen_next   = bytes_seen_reg;
        sign_seen_next    = sign_seen_reg;
        form_latched_next = form_latched_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (fire)
        begin
            if (work_reg.func == FUNC_ENCODE)
            begin
                result_valid_next      = 1'b1;
                result_next.value_out  = '0;
                result_next.byte_count = work_reg.n;
                if (work_reg.err)
                begin
                    result_next.kind     = KIND_ERROR;
                    result_next.out_byte = 8'd0;
                    result_next.last     = 1'b1;
                end
                else
                begin
                    result_next.kind     = KIND_BYTE;
                    result_next.out_byte = {!last_enc, data7};
                    result_next.last     = last_enc;
                    idx_next             = idx_reg + 4'd1;
                end
            end
            else
            begin
                form_latched_next = form;
                if (dec_val || dec_err)
                begin
                    result_valid_next      = 1'b1;
                    result_next.kind       = dec_val ? KIND_VALUE : KIND_ERROR;
                    result_next.out_byte   = 8'd0;
                    result_next.last       = 1'b1;
                    result_next.value_out  = dec_val
                                             ? $signed(sign ? (64'd0 - acc_new) : acc_new)
                                             : 64'sd0;
                    result_next.byte_count = cnt_new;
                    acc_next               = '0;
                    bytes_seen_next        = 4'd0;
                    sign_seen_next         = 1'b0;
                end
                else
                begin
                    acc_next        = acc_new;
                    bytes_seen_next = cnt_new;
                    sign_seen_next  = sign;
                end
            end
        end

        if (work_done)
        begin
            work_valid_next = 1'b0;
        end

        if (accept)
        begin
            work_valid_next      = 1'b1;
            idx_next             = 4'd0;
            work_next.func       = item.func;
            work_next.sform      = item.signed_form;
            work_next.mag        = mag;
            work_next.sbit       = neg;
            work_next.n          = n_need;
            work_next.err        = item.room < n_need;
            work_next.in_byte    = item.in_byte;
            work_next.buffer_end = item.buffer_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg   <= 1'b0;
            idx_reg          <= 4'd0;
            acc_reg          <= '0;
            bytes_seen_reg   <= 4'd0;
            sign_seen_reg    <= 1'b0;
            form_latched_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            work_valid_reg   <= work_valid_next;
            idx_reg          <= idx_next;
            acc_reg          <= acc_next;
            bytes_seen_reg   <= bytes_seen_next;
            sign_seen_reg    <= sign_seen_next;
            form_latched_reg <= form_latched_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: design/varint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_checker: port-level checks for the varint codec
// Watches the result channel for malformed bursts and results, and item stalls.
// ----------------------------------------------------------------------------
module varint_checker
    import varint_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

    // continuation bit of an encoded byte is the inverse of last
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_BYTE |-> result.out_byte[7] == !result.last)
        else $error("encoded byte continuation bit disagrees with last");

    // value and error results close their run and carry a count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_VALUE || result.kind == KIND_ERROR)
        |-> result.last && result.byte_count != 4'd0 && result.out_byte == 8'd0)
        else $error("value or error result malformed");

    // an unfinished encode burst continues with bytes only
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.kind == KIND_BYTE && !result.last
        |=> !result_valid || result.kind == KIND_BYTE)
        else $error("encode burst interrupted");

    // item side stalls with a free result side only while a burst advances
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall && !result_stall |=> result_valid)
        else $error("item stalled without result progress");

endmodule

bind varint_codec varint_checker u_varint_checker (.*);

FILE: tb/varint_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_codec_tb: self-checking testbench of the varint codec
// Walks a short table of directed encode and decode items, then drives
// random values and byte streams. Most of the streams are well formed, the
// rest are broken or noise. Both handshakes idle and stall at random. Every
// result is checked against its table entry or a cycle-free codec predictor.
// ----------------------------------------------------------------------------
module varint_codec_tb;
    import varint_pkg::*;

    localparam int ITEM_TARGET  = 330;
    localparam int HOLD_AT      = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 260;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        item_t   item;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Predictor copy of the decode state
    logic [63:0] acc_q = '0;
    logic [3:0]  seen_q = '0;
    logic        neg_q = 1'b0;
    logic        form_q = 1'b0;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];
    int        mismatches = 0;
    int        accepted_items = 0;
    int        burst_left = 0;
    int        cycle_count = 0;
    bit        long_hold = 1'b0;

    varint_codec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("varint_codec_tb failed");
            $finish;
        end
    end

    function automatic result_t byte_res(logic [7:0] b, logic last, logic [3:0] n);
        result_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.out_byte = b;
        r.last = last;
        r.byte_count = n;
        return r;
    endfunction

    function automatic result_t value_res(logic [63:0] v, logic [3:0] n);
        result_t r;
        r = '0;
        r.kind = KIND_VALUE;
        r.last = 1'b1;
        r.value_out = v;
        r.byte_count = n;
        return r;
    endfunction

    function automatic result_t error_res(logic [3:0] n);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.last = 1'b1;
        r.byte_count = n;
        return r;
    endfunction

    // Fields the function does not read get random content.
    function automatic item_t enc_item(logic sf, logic [63:0] v, logic [3:0] room);
        item_t it;
        it.func = FUNC_ENCODE;
        it.signed_form = sf;
        it.value_in = v;
        it.room = room;
        it.in_byte = 8'($urandom);
        it.buffer_end = 1'($urandom);
        return it;
    endfunction

    function automatic item_t dec_item(logic sf, logic [7:0] b, logic end_flag);
        item_t it;
        it.func = FUNC_DECODE;
        it.signed_form = sf;
        it.value_in = {$urandom, $urandom};
        it.room = 4'($urandom);
        it.in_byte = b;
        it.buffer_end = end_flag;
        return it;
    endfunction

    function automatic stim_row_t checked(item_t it);
        stim_row_t row;
        row.item = it;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t known(item_t it, result_t want);
        stim_row_t row;
        row.item = it;
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: v = 64'h0;
                1: v = 64'hFFFF_FFFF_FFFF_FFFF;
                2: v = 64'h8000_0000_0000_0000;
                3: v = 64'h7FFF_FFFF_FFFF_FFFF;
                default: v = 64'h1;
            endcase
        end
        else
        begin
            // Spread the magnitude over all encoded lengths
            v = {$urandom, $urandom} >> $urandom_range(0, 64);
            if ($urandom_range(0, 3) == 0)
                v = 64'd0 - v;
        end
        return v;
    endfunction

    function automatic item_t rand_encode();
        logic [3:0] room;
        if ($urandom_range(0, 2) != 0)
            room = 4'($urandom_range(10, 15));
        else
            room = 4'($urandom_range(0, 10));
        return enc_item(1'($urandom), rand_value(), room);
    endfunction

    // Expected results of one accepted item; advances the decode state.
    function automatic void predict_codec(input item_t it, ref result_t res[$]);
        logic [63:0] mag;
        logic [63:0] limit;
        logic [7:0]  b;
        logic        neg;
        int          n;
        int          sh;
        int          i;
        res.delete();
        if (it.func == FUNC_ENCODE)
        begin
            neg = it.signed_form && it.value_in[63];
            mag = neg ? 64'd0 - it.value_in : it.value_in;
            limit = it.signed_form ? 64'h3F : 64'h7F;
            n = 1;
            while (n < MAX_BYTES && mag > limit)
            begin
                limit = {limit[56:0], 7'h7F};
                n++;
            end
            if (int'(it.room) < n)
                res.push_back(error_res(4'(n)));
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    if (i == 0)
                        b = (mag[7:0] & (it.signed_form ? 8'h3F : 8'h7F))
                            | (neg ? 8'h40 : 8'h00);
                    else
                    begin
                        sh = (it.signed_form ? 6 : 7) + (i - 1) * 7;
                        b = 8'((mag >> sh) & 64'h7F);
                    end
                    if (i + 1 < n)
                        b[7] = 1'b1;
                    res.push_back(byte_res(b, i + 1 == n, 4'(n)));
                end
            end
        end
        else
        begin
            if (seen_q == 4'd0)
            begin
                form_q = it.signed_form;
                if (form_q)
                begin
                    neg_q = it.in_byte[6];
                    acc_q = {58'd0, it.in_byte[5:0]};
                end
                else
                begin
                    neg_q = 1'b0;
                    acc_q = {57'd0, it.in_byte[6:0]};
                end
            end
            else
            begin
                sh = form_q ? 6 + (int'(seen_q) - 1) * 7 : int'(seen_q) * 7;
                if (sh < 64)
                    acc_q = acc_q | ({57'd0, it.in_byte[6:0]} << sh);
            end
            seen_q = seen_q + 4'd1;
            if (!it.in_byte[7] || int'(seen_q) >= MAX_BYTES || it.buffer_end)
            begin
                if (!it.in_byte[7])
                    res.push_back(value_res(neg_q ? 64'd0 - acc_q : acc_q, seen_q));
                else
                    res.push_back(error_res(seen_q));
                acc_q = '0;
                seen_q = '0;
                neg_q = 1'b0;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (long_hold)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send(input item_t it, input bit typed, input result_t want);
        result_t got[$];
        int      gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        accepted_items++;
        predict_codec(it, got);
        if (typed)
            expected_results.push_back(want);
        else
            foreach (got[k])
                expected_results.push_back(got[k]);
    endtask

    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        if (mismatches < REPORT_MAX)
        begin
            $display("%s: want kind=%0d byte=%02h last=%0b value=%016h count=%0d",
                     what, want.kind, want.out_byte, want.last, want.value_out,
                     want.byte_count);
            $display("%s: got  kind=%0d byte=%02h last=%0b value=%016h count=%0d",
                     what, got.kind, got.out_byte, got.last, got.value_out,
                     got.byte_count);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0, result);
            else
            begin
                want = expected_results.pop_front();
                if (result.kind !== want.kind || result.out_byte !== want.out_byte
                    || result.last !== want.last || result.value_out !== want.value_out
                    || result.byte_count !== want.byte_count)
                    report_mismatch("result mismatch", want, result);
            end
        end
    end

    // Result side back-pressure, with one long hold-off
    initial
    begin
        int  len;
        int  mode;
        bit  hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (!hold_done && accepted_items >= HOLD_AT)
            begin
                long_hold = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                len = $urandom_range(1, 40);
                mode = $urandom_range(0, 9);
                if (mode < 3)
                begin
                    result_stall <= 1'b0;
                    repeat (len) @(posedge clk);
                end
                else if (mode < 9)
                begin
                    repeat (len)
                    begin
                        result_stall <= ($urandom_range(0, 2) == 0);
                        @(posedge clk);
                    end
                end
                else
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int   k;
        int   len;
        int   r;
        bit   paused;
        logic cont;
        paused = 1'b0;

        directed_rows.push_back(known(enc_item(1'b0, 64'h0, 4'd1), byte_res(8'h00, 1'b1, 4'd1)));
        directed_rows.push_back(known(enc_item(1'b0, 64'h0, 4'd0), error_res(4'd1)));
        directed_rows.push_back(checked(enc_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd10)));
        directed_rows.push_back(known(enc_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9),
                                      error_res(4'd10)));
        directed_rows.push_back(known(enc_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1),
                                      byte_res(8'h41, 1'b1, 4'd1)));
        // Room above ten counts as enough
        directed_rows.push_back(checked(enc_item(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 4'd15)));
        directed_rows.push_back(known(enc_item(1'b1, 64'd63, 4'd1), byte_res(8'h3F, 1'b1, 4'd1)));
        directed_rows.push_back(known(enc_item(1'b1, 64'd64, 4'd1), error_res(4'd2)));
        directed_rows.push_back(known(enc_item(1'b0, 64'd128, 4'd1), error_res(4'd2)));
        directed_rows.push_back(known(dec_item(1'b0, 8'h00, 1'b0), value_res(64'd0, 4'd1)));
        directed_rows.push_back(known(dec_item(1'b0, 8'h7F, 1'b0), value_res(64'd127, 4'd1)));
        directed_rows.push_back(known(dec_item(1'b1, 8'h41, 1'b0),
                                      value_res(64'hFFFF_FFFF_FFFF_FFFF, 4'd1)));
        // Negative zero decodes to zero
        directed_rows.push_back(known(dec_item(1'b1, 8'h40, 1'b0), value_res(64'd0, 4'd1)));
        directed_rows.push_back(known(dec_item(1'b0, 8'h80, 1'b1), error_res(4'd1)));
        // Signed chain of ten continuation bytes, with the most negative value
        // encoded in its middle; the form flag is ignored after the first byte
        directed_rows.push_back(checked(dec_item(1'b1, 8'hFF, 1'b0)));
        directed_rows.push_back(checked(enc_item(1'b1, 64'h8000_0000_0000_0000, 4'd10)));
        for (k = 0; k < 8; k++)
            directed_rows.push_back(checked(dec_item(1'b0, 8'hFF, 1'b0)));
        directed_rows.push_back(known(dec_item(1'b1, 8'hFF, 1'b0), error_res(4'd10)));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        while (accepted_items < ITEM_TARGET)
        begin
            if (!paused && accepted_items >= PAUSE_AT)
            begin
                // Hold off the sender until every result is back
                paused = 1'b1;
                item_valid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 35)
                send(rand_encode(), 1'b0, '0);
            else if (r < 85)
            begin
                // Well-formed value, now and then with an encode inside it
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10)
                                                  : $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                begin
                    if (k > 0 && $urandom_range(0, 9) == 0)
                        send(rand_encode(), 1'b0, '0);
                    cont = (k + 1 < len) ? 1'b1 : 1'b0;
                    send(dec_item(1'($urandom), {cont, 7'($urandom)},
                                  cont ? 1'b0 : 1'($urandom)), 1'b0, '0);
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // Truncated by buffer end
                        len = $urandom_range(1, 9);
                        for (k = 0; k < len; k++)
                            send(dec_item(1'($urandom), {1'b1, 7'($urandom)},
                                          (k + 1 == len) ? 1'b1 : 1'b0), 1'b0, '0);
                    end
                    1:
                    begin
                        // Too long: error on the tenth byte, the rest start over
                        len = $urandom_range(10, 12);
                        for (k = 0; k < len; k++)
                            send(dec_item(1'($urandom), {1'b1, 7'($urandom)}, 1'b0),
                                 1'b0, '0);
                    end
                    default:
                        send(dec_item(1'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
                endcase
            end
        end
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("varint_codec_tb passed");
        else
            $display("varint_codec_tb failed");
        $finish;
    end

endmodule
